FILE: src/dab_pkg.sv
// ----------------------------------------------------------------------------
// dab_pkg
// shared sizes, types and the inverse dct weight table of the block decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dab_pkg;

  localparam int BLOCK         = 64;
  localparam int COS_FRAC_BITS = 16;

  localparam int COEFF_W = 24;                     // stored coefficient
  localparam int W_W     = COS_FRAC_BITS + 2;      // signed q1.frac weight
  localparam int ACC_W   = 48;                     // wrapping accumulator
  localparam int PHASES  = 4 * BLOCK;              // one full cosine period
  localparam int PH_W    = $clog2(PHASES);
  localparam int K_W     = $clog2(BLOCK);
  localparam int CNT_W   = $clog2(BLOCK + 1);

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
  localparam longint      ONE_Q30 = 64'sd1073741824;

  // angle of one phase step, pi/(2*BLOCK) in q62
  localparam logic [63:0] PI_STEP = PI_Q62 / (2 * BLOCK);

  // configuration register indexes
  localparam logic REG_QUANT_STEP    = 1'b0;
  localparam logic REG_TOTAL_SAMPLES = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;   // first product of a sample
    logic last;    // last product of a sample
    logic blast;   // sample is the last one of the block
  } mac_ctl_t;

  typedef logic signed [W_W-1:0] wtab_t [PHASES];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // quotient truncated toward zero, positive divisor, by shift and subtract
  function automatic longint div_trunc(input longint num, input longint den);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [63:0] quo;
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], mag[b]};
      if (rem >= 64'(den)) begin
        rem    = rem - 64'(den);
        quo[b] = 1'b1;
      end
    end
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  // cos(pi*r/(2*BLOCK)) in q30 by a taylor series, r in [0, BLOCK]
  function automatic longint cos_fq(input int r);
    logic [63:0] x;
    logic [63:0] x2;
    longint      x2s;
    longint      t;
    longint      d;
    x   = (PI_STEP * 64'(r) + (64'd1 << 31)) >> 32;
    x2  = (x * x + (64'd1 << 29)) >> 30;
    x2s = longint'(x2);
    t   = ONE_Q30;
    for (int i = 10; i >= 1; i--) begin
      d = longint'((2 * i - 1) * (2 * i));
      t = ONE_Q30 - div_trunc((x2s * t) / ONE_Q30, d);
    end
    return t;
  endfunction

  function automatic longint cos_phase(input int j);
    longint c;
    if (j <= BLOCK) c = cos_fq(j);
    else if (j < 2 * BLOCK) c = -cos_fq(2 * BLOCK - j);
    else if (j < 3 * BLOCK) c = -cos_fq(j - 2 * BLOCK);
    else c = cos_fq(4 * BLOCK - j);
    return c;
  endfunction

  // q60 product rounded half away from zero to the weight format
  function automatic logic signed [W_W-1:0] round_w(input longint p);
    logic        neg;
    logic [63:0] m;
    neg = (p < 0);
    m   = neg ? 64'(-p) : 64'(p);
    m   = (m + (64'd1 << (59 - COS_FRAC_BITS))) >> (60 - COS_FRAC_BITS);
    m   = neg ? -m : m;
    return m[W_W-1:0];
  endfunction

  localparam longint ALPHA_0 = longint'(int_sqrt((64'd1 << 60) / BLOCK));
  localparam longint ALPHA_K = longint'(int_sqrt((64'd1 << 61) / BLOCK));

  function automatic wtab_t build_wtab();
    wtab_t tab;
    for (int j = 0; j < PHASES; j++) begin
      tab[j] = round_w(ALPHA_K * cos_phase(j));
    end
    return tab;
  endfunction

  // weight of the dc term (phase zero, its own alpha)
  localparam logic signed [W_W-1:0] W_DC = round_w(ALPHA_0 * ONE_Q30);

  // weights of all other terms, indexed by k*(2n+1) mod 4*BLOCK
  localparam wtab_t WTAB = build_wtab();

endpackage

`default_nettype wire

FILE: src/dab_cell.sv
// ----------------------------------------------------------------------------
// dab_cell
// one coefficient slot of the shifting coefficient chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dab_cell
  import dab_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      shift,
  input  wire logic signed [COEFF_W-1:0] d,
  output logic signed [COEFF_W-1:0]      q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

FILE: src/dab_mac.sv
// ----------------------------------------------------------------------------
// dab_mac
// shared multiply-accumulate and sample conversion pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dab_mac
  import dab_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic signed [COEFF_W-1:0] coeff_in,
  input  wire logic signed [W_W-1:0]     weight_in,
  input  wire mac_ctl_t                  ctl_in,
  output logic                           strobe,
  output logic signed [15:0]             sample,
  output logic                           block_end
);

  logic signed [COEFF_W-1:0]     c1;
  logic signed [W_W-1:0]         w1;
  mac_ctl_t                      ctl1;
  logic signed [COEFF_W+W_W-1:0] prod_full;
  logic signed [ACC_W-1:0]       prod;
  mac_ctl_t                      ctl2;
  logic signed [ACC_W-1:0]       acc;
  logic                          acc_done;
  logic                          acc_blast;
  logic signed [ACC_W-1:0]       biased;
  logic signed [ACC_W-1:0]       shifted;
  logic signed [15:0]            clamped;

  assign prod_full = c1 * w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1     <= '0;
      ctl2     <= '0;
      acc_done <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      ctl1     <= ctl_in;
      ctl2     <= ctl1;
      acc_done <= ctl2.valid & ctl2.last;
      strobe   <= acc_done;
    end
  end

  always_ff @(posedge clk) begin
    c1   <= coeff_in;
    w1   <= weight_in;
    prod <= ACC_W'(prod_full);
    if (ctl2.valid) begin
      acc       <= ctl2.first ? prod : acc + prod;
      acc_blast <= ctl2.blast;
    end
    sample    <= clamped;
    block_end <= acc_blast;
  end

  // divide by 2^frac truncating toward zero, then clamp to 16 bits
  always_comb begin
    biased  = acc + (acc[ACC_W-1] ? ACC_W'((64'd1 << COS_FRAC_BITS) - 1) : '0);
    shifted = biased >>> COS_FRAC_BITS;
    if (shifted > 48'sd32767) begin
      clamped = 16'sh7FFF;
    end else if (shifted < -48'sd32768) begin
      clamped = 16'sh8000;
    end else begin
      clamped = shifted[15:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/dct_audio_block_decoder.sv
// ----------------------------------------------------------------------------
// dct_audio_block_decoder
// inverse dct-ii audio block decoder with a rotating coefficient chain
// ----------------------------------------------------------------------------
// usage
//   input: one offset-binary coefficient per beat, taken at a clock edge with
//   start high and busy low. the coefficient is de-biased, scaled by
//   quant_step and shifted into a chain of BLOCK cells.
//   when the chain holds a full block, busy rises and the chain rotates once
//   per sample through one shared multiply-accumulate unit, one product per
//   cycle; the samples of a block leave one after another, and no new
//   coefficient is taken until the last sample of the block has left.
//   output: each sample is shown for exactly one cycle with strobe high;
//   block_end marks the last sample of a block, stream_end the sample that
//   brings the count up to total_samples. the receiver cannot stall.
//   a full block past total_samples is loaded, emits nothing, busy stays low.
//   config: cfg_wen writes cfg_data to the register at cfg_index; the user
//   must write only while the block is idle, the block itself does not
//   enforce it; quant_step resets to 1, total_samples to 0.
//   reset: synchronous, clears the load position, sample count and control;
//   coefficient cells are not cleared (always written before use).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dct_audio_block_decoder
  import dab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] coeff_word,
  output logic             strobe,
  output logic signed [15:0] sample,
  output logic             block_end,
  output logic             stream_end,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                    state;
  logic [7:0]                quant_step;
  logic [31:0]               total_samples;
  logic [31:0]               samples_written;
  logic [K_W-1:0]            load_index;
  logic [K_W-1:0]            k;
  logic [CNT_W-1:0]          n;
  logic [CNT_W-1:0]          cur;
  logic [PH_W-1:0]           phase;
  logic [PH_W-1:0]           phase_step;
  logic                      stream_last;

  logic                      accept;
  logic                      shift;
  logic signed [15:0]        coeff_s;
  logic signed [8:0]         qstep_s;
  logic signed [24:0]        scaled;
  logic signed [COEFF_W-1:0] coeff_new;
  logic [PH_W:0]             phase_sum;
  logic [PH_W-1:0]           phase_next;
  logic [32:0]               remain;
  logic                      remain_le;
  logic                      k_last;
  logic                      n_last;
  logic signed [W_W-1:0]     weight;
  mac_ctl_t                  ctl;
  logic                      mac_block_end;

  logic signed [COEFF_W-1:0] chain [BLOCK];
  logic signed [COEFF_W-1:0] chain_d [BLOCK];

  assign busy   = (state != ST_LOAD);
  assign accept = start & ~busy;
  assign shift  = accept | (state == ST_RUN);

  // de-bias by flipping the sign bit, then scale
  assign coeff_s   = {~coeff_word[15], coeff_word[14:0]};
  assign qstep_s   = {1'b0, quant_step};
  assign scaled    = coeff_s * qstep_s;
  assign coeff_new = scaled[COEFF_W-1:0];

  // chain: shifts toward cell 0; cell 0 feeds the mac and wraps to the tail
  always_comb begin
    for (int i = 0; i < BLOCK - 1; i++) begin
      chain_d[i] = chain[i+1];
    end
    chain_d[BLOCK-1] = accept ? coeff_new : chain[0];
  end

  for (genvar g = 0; g < BLOCK; g++) begin : g_cell
    dab_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (chain_d[g]),
      .q     (chain[g])
    );
  end

  // phase k*(2n+1) mod 4*BLOCK kept by add and wrap
  assign phase_sum  = {1'b0, phase} + {1'b0, phase_step};
  assign phase_next = (phase_sum >= (PH_W+1)'(PHASES)) ?
                      PH_W'(phase_sum - (PH_W+1)'(PHASES)) : phase_sum[PH_W-1:0];

  assign k_last = (k == K_W'(BLOCK - 1));
  assign n_last = (n == cur - CNT_W'(1));

  assign weight = (k == '0) ? W_DC : WTAB[phase];

  always_comb begin
    ctl.valid = (state == ST_RUN);
    ctl.first = (k == '0);
    ctl.last  = k_last;
    ctl.blast = n_last;
  end

  // samples left in the stream, decided on the beat that completes a block
  assign remain    = {1'b0, total_samples} - {1'b0, samples_written};
  assign remain_le = (remain[31:0] <= 32'(BLOCK));

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_step    <= 8'd1;
      total_samples <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_QUANT_STEP:    quant_step    <= cfg_data[7:0];
        REG_TOTAL_SAMPLES: total_samples <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      load_index      <= '0;
      samples_written <= '0;
      k               <= '0;
      n               <= '0;
      cur             <= '0;
      phase           <= '0;
      phase_step      <= '0;
      stream_last     <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (load_index == K_W'(BLOCK - 1)) begin
              load_index <= '0;
              // block full: run only while samples are still owed
              if (!remain[32] && remain[31:0] != '0) begin
                state       <= ST_RUN;
                cur         <= remain_le ? remain[CNT_W-1:0] : CNT_W'(BLOCK);
                stream_last <= remain_le;
                k           <= '0;
                n           <= '0;
                phase       <= '0;
                phase_step  <= PH_W'(1);
              end
            end else begin
              load_index <= load_index + K_W'(1);
            end
          end
        end
        ST_RUN: begin
          if (k_last) begin
            k          <= '0;
            phase      <= '0;
            n          <= n + CNT_W'(1);
            phase_step <= phase_step + PH_W'(2);
            if (n_last) begin
              state           <= ST_DRAIN;
              samples_written <= samples_written + 32'(cur);
            end
          end else begin
            k     <= k + K_W'(1);
            phase <= phase_next;
          end
        end
        ST_DRAIN: begin
          // wait for the last sample of the block to leave the mac
          if (strobe && mac_block_end) begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  dab_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .coeff_in  (chain[0]),
    .weight_in (weight),
    .ctl_in    (ctl),
    .strobe    (strobe),
    .sample    (sample),
    .block_end (mac_block_end)
  );

  assign block_end  = mac_block_end;
  assign stream_end = mac_block_end & stream_last;

endmodule

`default_nettype wire

FILE: src/dab_chk.sv
// ----------------------------------------------------------------------------
// dab_chk
// port-level checks of the block decoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dab_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic strobe,
  input wire logic block_end,
  input wire logic stream_end
);

  // reset leaves the block idle with nothing on the output
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("block not idle after reset");

  // samples only appear while a block is being computed
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("sample beat while idle");

  // end of stream always coincides with the end of a block
  a_stream_block: assert property (@(posedge clk) disable iff (rst)
      strobe && stream_end |-> block_end)
    else $error("stream end without block end");

  // the last sample of a block frees the input right after it
  a_block_free: assert property (@(posedge clk) disable iff (rst)
      strobe && block_end |=> !busy && !strobe)
    else $error("block end did not release the block");

endmodule

bind dct_audio_block_decoder dab_chk u_dab_chk (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .strobe     (strobe),
  .block_end  (block_end),
  .stream_end (stream_end)
);

`default_nettype wire
